FILE: rtl/core/ptlrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptlrf_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W = 4;
    localparam int COUNT_W = 5;

    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_SEQ_CHECK = 3'd1;
    localparam logic [2:0] REQ_FIND_MAC = 3'd2;
    localparam logic [2:0] REQ_FIND_ROLE = 3'd3;
    localparam logic [2:0] REQ_READ_SLOT = 3'd4;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_UPDATED = 2'd1;
    localparam logic [1:0] STATUS_ADDED = 2'd2;
    localparam logic [1:0] STATUS_REPLACED = 2'd3;

    typedef struct packed {
        logic [31:0] last_seq;
        logic [31:0] seen;
        logic [7:0]  role;
        logic [15:0] node;
        logic [47:0] mac;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/core/ptlrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptlrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/peer_table_lru_replay_filter.sv
// Register, find by MAC and find by role scan the N entries in use (a match ends the scan
// early), then pass through the read and modify states; a sequence check, a slot read, an
// unknown request or any request on an empty table goes straight to read and modify.
// One request in work at a time: a new transaction is taken only in the idle state, after
// the last result is loaded into the output register; the scan reads one entry per cycle.
// Reset clears the entry count, started flags and handshake state, not the table memory.
`timescale 1ns / 1ps
`default_nettype none

module peer_table_lru_replay_filter (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0: peer_mac, node_code, role_code, slot_index, seq_number, now_ms.
    input  wire logic [143:0] s_tdata,
    // Fields from bit 0: req_type.
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0: result_slot, reg_status, seq_accepted, peer_total, entry_mac,
    // entry_node, entry_role, entry_seen, entry_last_seq, entry_seq_started.
    output logic [151:0]      m_tdata,
    // Fields from bit 0: hit.
    output logic [0:0]        m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_MODIFY = 2'd3;

    localparam int SW = ptlrf_pkg::SLOT_W;
    localparam int CW = ptlrf_pkg::COUNT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(ptlrf_pkg::TABLE_ENTRIES);

    logic [1:0] state_reg, state_next;
    logic [CW-1:0] used_count_reg, used_count_next;
    logic [ptlrf_pkg::TABLE_ENTRIES-1:0] started_reg, started_next;

    logic [2:0]  req_reg, req_next;
    logic [47:0] mac_reg, mac_next;
    logic [15:0] node_reg, node_next;
    logic [7:0]  role_reg, role_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] now_reg, now_next;

    logic [SW-1:0] slot_reg, slot_next;
    logic          target_valid_reg, target_valid_next;
    logic [1:0]    status_reg, status_next;

    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [SW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [SW-1:0] best_idx_reg, best_idx_next;
    logic [31:0]   best_seen_reg, best_seen_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [151:0]  m_tdata_reg, m_tdata_next;
    logic          m_hit_reg, m_hit_next;

    logic                      ram_we;
    logic [SW-1:0]             ram_raddr;
    logic [ptlrf_pkg::ENTRY_W-1:0] ram_rdata;
    ptlrf_pkg::entry_t         rd_ent;
    ptlrf_pkg::entry_t         new_ent;

    logic          issue;
    logic          match;
    logic          last_cmp;
    logic          cand_better;
    logic [SW-1:0] cand_idx;
    logic          out_free;
    logic          accepted;
    logic          started_after;
    logic [CW-1:0] total_after;
    logic [5:0]    s_pad;

    assign rd_ent = ptlrf_pkg::entry_t'(ram_rdata);
    assign s_pad = s_tdata[143:138] & {2'b00, s_tdata[139:136]} & 6'd0;
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_idx_reg[SW-1:0] : slot_reg;

    ptlrf_ram #(
        .WIDTH(ptlrf_pkg::ENTRY_W),
        .DEPTH(ptlrf_pkg::TABLE_ENTRIES)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(slot_reg),
        .wr_data(new_ent),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_hit_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        issue = scan_idx_reg < used_count_reg;
        if (req_reg == ptlrf_pkg::REQ_FIND_ROLE) begin
            match = (rd_ent.role == role_reg);
        end else begin
            match = (rd_ent.mac == mac_reg);
        end
        last_cmp = (CW'(cmp_idx_reg) + CW'(1)) == used_count_reg;
        cand_better = (cmp_idx_reg == '0) || (rd_ent.seen < best_seen_reg);
        cand_idx = cand_better ? cmp_idx_reg : best_idx_reg;
    end

    always_comb begin
        state_next = state_reg;
        used_count_next = used_count_reg;
        started_next = started_reg;
        req_next = req_reg;
        mac_next = mac_reg;
        node_next = node_reg;
        role_next = role_reg;
        seq_next = seq_reg;
        now_next = now_reg;
        slot_next = slot_reg;
        target_valid_next = target_valid_reg;
        status_next = status_reg;
        scan_idx_next = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_seen_next = best_seen_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        m_hit_next = m_hit_reg;
        ram_we = 1'b0;
        new_ent = rd_ent;
        accepted = 1'b0;
        started_after = started_reg[slot_reg];
        total_after = used_count_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tuser;
                    mac_next = s_tdata[47:0];
                    node_next = s_tdata[63:48];
                    role_next = s_tdata[71:64];
                    slot_next = s_tdata[75:72] | s_pad[3:0];
                    seq_next = s_tdata[107:76];
                    now_next = s_tdata[139:108];
                    status_next = ptlrf_pkg::STATUS_NONE;
                    scan_idx_next = '0;
                    target_valid_next = 1'b0;
                    state_next = ST_READ;
                    case (s_tuser)
                        ptlrf_pkg::REQ_REGISTER: begin
                            if (used_count_reg == '0) begin
                                slot_next = '0;
                                target_valid_next = 1'b1;
                                status_next = ptlrf_pkg::STATUS_ADDED;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        ptlrf_pkg::REQ_FIND_MAC, ptlrf_pkg::REQ_FIND_ROLE: begin
                            if (used_count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        ptlrf_pkg::REQ_SEQ_CHECK, ptlrf_pkg::REQ_READ_SLOT: begin
                            target_valid_next = CW'(s_tdata[75:72]) < used_count_reg;
                        end
                        default: begin
                            target_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmp_valid_next = issue;
                cmp_idx_next = scan_idx_reg[SW-1:0];
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (cmp_valid_reg) begin
                    best_idx_next = cand_idx;
                    if (cand_better) begin
                        best_seen_next = rd_ent.seen;
                    end
                    if (match) begin
                        slot_next = cmp_idx_reg;
                        target_valid_next = 1'b1;
                        if (req_reg == ptlrf_pkg::REQ_REGISTER) begin
                            status_next = ptlrf_pkg::STATUS_UPDATED;
                        end
                        cmp_valid_next = 1'b0;
                        state_next = ST_READ;
                    end else if (last_cmp) begin
                        cmp_valid_next = 1'b0;
                        state_next = ST_READ;
                        if (req_reg == ptlrf_pkg::REQ_REGISTER) begin
                            target_valid_next = 1'b1;
                            if (used_count_reg == FULL_COUNT) begin
                                slot_next = cand_idx;
                                status_next = ptlrf_pkg::STATUS_REPLACED;
                            end else begin
                                slot_next = used_count_reg[SW-1:0];
                                status_next = ptlrf_pkg::STATUS_ADDED;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                case (req_reg)
                    ptlrf_pkg::REQ_REGISTER: begin
                        if (status_reg == ptlrf_pkg::STATUS_UPDATED) begin
                            if (node_reg != '0) begin
                                new_ent.node = node_reg;
                            end
                            if (role_reg != '0) begin
                                new_ent.role = role_reg;
                            end
                            new_ent.seen = now_reg;
                        end else begin
                            new_ent.mac = mac_reg;
                            new_ent.node = node_reg;
                            new_ent.role = role_reg;
                            new_ent.seen = now_reg;
                            new_ent.last_seq = '0;
                            started_after = 1'b0;
                            if (status_reg == ptlrf_pkg::STATUS_ADDED) begin
                                total_after = used_count_reg + CW'(1);
                            end
                        end
                    end
                    ptlrf_pkg::REQ_SEQ_CHECK: begin
                        if (target_valid_reg &&
                            (!started_reg[slot_reg] || seq_reg > rd_ent.last_seq)) begin
                            accepted = 1'b1;
                            new_ent.last_seq = seq_reg;
                            started_after = 1'b1;
                        end
                    end
                    default: begin
                        accepted = 1'b0;
                    end
                endcase
                if (out_free) begin
                    ram_we = target_valid_reg &&
                             ((req_reg == ptlrf_pkg::REQ_REGISTER) || accepted);
                    started_next[slot_reg] = target_valid_reg ? started_after
                                                              : started_reg[slot_reg];
                    used_count_next = total_after;
                    m_tvalid_next = 1'b1;
                    m_hit_next = target_valid_reg;
                    m_tdata_next = '0;
                    m_tdata_next[11:7] = total_after;
                    if (target_valid_reg) begin
                        m_tdata_next[3:0] = slot_reg;
                        m_tdata_next[5:4] = status_reg;
                        m_tdata_next[6] = accepted;
                        m_tdata_next[59:12] = new_ent.mac;
                        m_tdata_next[75:60] = new_ent.node;
                        m_tdata_next[83:76] = new_ent.role;
                        m_tdata_next[115:84] = new_ent.seen;
                        m_tdata_next[147:116] = new_ent.last_seq;
                        m_tdata_next[148] = started_after;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_count_reg <= '0;
            started_reg <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_count_reg <= used_count_next;
            started_reg <= started_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        mac_reg <= mac_next;
        node_reg <= node_next;
        role_reg <= role_next;
        seq_reg <= seq_next;
        now_reg <= now_next;
        slot_reg <= slot_next;
        target_valid_reg <= target_valid_next;
        status_reg <= status_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_seen_reg <= best_seen_next;
        m_tdata_reg <= m_tdata_next;
        m_hit_reg <= m_hit_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= FULL_COUNT)
        else $error("Entry count exceeds the table size.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(used_count_reg)) |->
        (used_count_reg == $past(used_count_reg) + CW'(1)))
        else $error("Entry count changed by other than one.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tdata_reg[5:4] != ptlrf_pkg::STATUS_NONE || m_tdata_reg[6]))
        |-> m_hit_reg)
        else $error("Result status given without a hit.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[6]) |-> m_tdata_reg[148])
        else $error("Accepted sequence number without the started flag.");
`endif

endmodule

`default_nettype wire
